### rtl/svpwm_pkg.sv
package svpwm_pkg;

  // item kinds on the input channel
  typedef enum logic {
    MODE_SET_ANGLE = 1'b0,
    MODE_TICK      = 1'b1
  } mode_e;

  localparam int unsigned FULL_TURN   = 360;
  localparam int unsigned SECTOR_SPAN = 60;
  localparam int unsigned OFFS_LAST   = 60;

  // angle / 360 as a multiply by 2^24/360 rounded up, exact over 16 bits
  localparam int unsigned TURN_RECIP = 46604;
  localparam int unsigned TURN_SHIFT = 24;

  // product / 100 as a multiply by 2^19/100 rounded up, exact over 15 bits
  localparam int unsigned PCT_RECIP = 5243;
  localparam int unsigned PCT_SHIFT = 19;

  localparam logic [6:0] PCT_RESET = 7'd100;
  localparam logic [7:0] START_END = 8'd220;
  localparam logic [7:0] END_MAX   = 8'd255;

  localparam logic [2:0] VEC_RESET     = 3'b100;
  localparam logic [2:0] VEC_ZERO_LOW  = 3'b000;
  localparam logic [2:0] VEC_ZERO_HIGH = 3'b111;

  localparam logic [7:0] DUR_FIRST [61] = '{
    8'd220, 8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd200, 8'd197,
    8'd195, 8'd192, 8'd189, 8'd186, 8'd183, 8'd180, 8'd176, 8'd173, 8'd170, 8'd167,
    8'd163, 8'd160, 8'd156, 8'd153, 8'd149, 8'd146, 8'd142, 8'd138, 8'd135, 8'd131,
    8'd127, 8'd123, 8'd119, 8'd115, 8'd111, 8'd107, 8'd103, 8'd99,  8'd95,  8'd91,
    8'd87,  8'd83,  8'd79,  8'd74,  8'd70,  8'd66,  8'd61,  8'd57,  8'd53,  8'd48,
    8'd44,  8'd40,  8'd35,  8'd31,  8'd27,  8'd22,  8'd18,  8'd13,  8'd9,   8'd4,
    8'd0
  };

  localparam logic [7:0] DUR_SECOND [61] = '{
    8'd0,   8'd4,   8'd9,   8'd13,  8'd18,  8'd22,  8'd27,  8'd31,  8'd35,  8'd40,
    8'd44,  8'd48,  8'd53,  8'd57,  8'd61,  8'd66,  8'd70,  8'd74,  8'd79,  8'd83,
    8'd87,  8'd91,  8'd95,  8'd99,  8'd103, 8'd107, 8'd111, 8'd115, 8'd119, 8'd123,
    8'd127, 8'd131, 8'd135, 8'd138, 8'd142, 8'd146, 8'd149, 8'd153, 8'd156, 8'd160,
    8'd163, 8'd167, 8'd170, 8'd173, 8'd176, 8'd180, 8'd183, 8'd186, 8'd189, 8'd192,
    8'd195, 8'd197, 8'd200, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215, 8'd218,
    8'd220
  };

  // first active vector duration at a sector offset
  function automatic logic [7:0] dur_first(input logic [5:0] offs);
    logic [7:0] res;
    res = 8'd0;
    if (offs <= 6'(OFFS_LAST)) begin
      res = DUR_FIRST[offs];
    end
    return res;
  endfunction

  // second active vector duration at a sector offset
  function automatic logic [7:0] dur_second(input logic [5:0] offs);
    logic [7:0] res;
    res = 8'd0;
    if (offs <= 6'(OFFS_LAST)) begin
      res = DUR_SECOND[offs];
    end
    return res;
  endfunction

  // active vector of a sector, sector six wraps to the first one
  function automatic logic [2:0] sector_vec(input logic [2:0] sect);
    logic [2:0] res;
    unique case (sect)
      3'd0:    res = 3'b100;
      3'd1:    res = 3'b110;
      3'd2:    res = 3'b010;
      3'd3:    res = 3'b011;
      3'd4:    res = 3'b001;
      3'd5:    res = 3'b101;
      default: res = 3'b100;
    endcase
    return res;
  endfunction

  // zero vector: all high after a two-bit vector, all low otherwise
  function automatic logic [2:0] zero_for(input logic [2:0] vec);
    logic [1:0] ones;
    ones = 2'(vec[0]) + 2'(vec[1]) + 2'(vec[2]);
    return (ones == 2'd2) ? VEC_ZERO_HIGH : VEC_ZERO_LOW;
  endfunction

endpackage

### rtl/space_vector_pwm_generator_core.sv
// Three-phase space-vector PWM generator.
// Input channel (in_valid_i / in_ready_o) carries mode_i and angle_i. A
// set-angle transfer reduces angle_i modulo 360, picks the sector vectors and
// scales the two vector durations by the power register, then restarts the
// 8-bit tick counter and drives the first vector. A tick transfer advances
// the counter and applies the compare A, compare B and wrap events.
// Output channel (out_valid_o / out_ready_i) gives one result per input
// transfer: phase_bits_o, first_end_o and second_end_o.
// A result is valid once its input has passed the angle divide stage, the
// table and scale stage, the percent divide stage and the state update
// stage. Throughput is one item per cycle while the receiver takes results.
// A stalled receiver holds the result; the stages behind it keep filling and
// in_ready_o falls only once every stage holds an item. The user must write
// the power register by cfg_we_i / cfg_wdata_i only while idle; the block
// does not enforce it. Reset gives power 100 and the state of a set-angle
// of zero: counter 0, both compares 220, drive 100, no result pending.
module space_vector_pwm_generator_core
  import svpwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  phase_bits_o,
  output logic [7:0]  first_end_o,
  output logic [7:0]  second_end_o
);

  logic [6:0] power_q;

  // stage valids and readies
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy, out_rdy;

  // stage payloads
  logic        a_mode_q;
  logic [15:0] a_angle_q;
  logic        b_mode_q;
  logic [15:0] b_angle_q;
  logic [7:0]  b_turns_q;
  logic        c_mode_q;
  logic [14:0] c_p1_q, c_p2_q;
  logic [2:0]  c_sect_q;
  logic        c_offs_zero_q;
  logic        d_mode_q;
  logic [7:0]  d_d1_q, d_d2_q;
  logic [2:0]  d_sect_q;
  logic        d_offs_zero_q;

  // pwm state
  logic [7:0] tick_q, tick_d;
  logic [7:0] cmp_a_q, cmp_a_d, cmp_b_q, cmp_b_d;
  logic [7:0] nxt_first_q, nxt_first_d, nxt_second_q, nxt_second_d;
  logic [2:0] first_vec_q, first_vec_d, second_vec_q, second_vec_d;
  logic [2:0] zero_vec_q, zero_vec_d, drive_q, drive_d;
  logic       upd;

  // power register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= PCT_RESET;
    end else if (cfg_we_i) begin
      power_q <= cfg_wdata_i;
    end
  end

  // ready chain from the output back to the input
  assign out_rdy    = !out_valid_q || out_ready_i;
  assign d_rdy      = !d_valid_q || out_rdy;
  assign c_rdy      = !c_valid_q || d_rdy;
  assign b_rdy      = !b_valid_q || c_rdy;
  assign a_rdy      = !a_valid_q || b_rdy;
  assign in_ready_o = a_rdy;
  assign upd        = d_valid_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_rdy)   a_valid_q   <= in_valid_i;
      if (b_rdy)   b_valid_q   <= a_valid_q;
      if (c_rdy)   c_valid_q   <= b_valid_q;
      if (d_rdy)   d_valid_q   <= c_valid_q;
      if (out_rdy) out_valid_q <= d_valid_q;
    end
  end

  // stage b: whole turns of the angle by reciprocal multiply
  logic [31:0] turn_prod;
  assign turn_prod = 32'(a_angle_q) * 32'(TURN_RECIP);

  // stage c: sector, offset, table lookup and power scaling
  logic [16:0] turn_span;
  logic [16:0] phi_full;
  logic [8:0]  phi;
  logic [2:0]  sect;
  logic [8:0]  sect_base;
  logic [5:0]  offs;

  assign turn_span = 17'(b_turns_q) * 17'(FULL_TURN);
  assign phi_full  = 17'(b_angle_q) - turn_span;
  assign phi       = phi_full[8:0];

  always_comb begin
    priority if (phi >= 9'(5 * SECTOR_SPAN)) sect = 3'd5;
    else if (phi >= 9'(4 * SECTOR_SPAN))     sect = 3'd4;
    else if (phi >= 9'(3 * SECTOR_SPAN))     sect = 3'd3;
    else if (phi >= 9'(2 * SECTOR_SPAN))     sect = 3'd2;
    else if (phi >= 9'(SECTOR_SPAN))         sect = 3'd1;
    else                                     sect = 3'd0;
  end

  assign sect_base = 9'(sect) * 9'(SECTOR_SPAN);
  assign offs      = 6'(phi - sect_base);

  // stage d: divide the scaled durations by 100 and saturate
  logic [27:0] q1_prod, q2_prod;
  logic [8:0]  q1, q2;
  assign q1_prod = 28'(c_p1_q) * 28'(PCT_RECIP);
  assign q2_prod = 28'(c_p2_q) * 28'(PCT_RECIP);
  assign q1      = q1_prod[PCT_SHIFT +: 9];
  assign q2      = q2_prod[PCT_SHIFT +: 9];

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_rdy) begin
      a_mode_q  <= mode_i;
      a_angle_q <= angle_i;
    end
    if (a_valid_q && b_rdy) begin
      b_mode_q  <= a_mode_q;
      b_angle_q <= a_angle_q;
      b_turns_q <= turn_prod[TURN_SHIFT +: 8];
    end
    if (b_valid_q && c_rdy) begin
      c_mode_q      <= b_mode_q;
      c_p1_q        <= 15'(dur_first(offs)) * 15'(power_q);
      c_p2_q        <= 15'(dur_second(offs)) * 15'(power_q);
      c_sect_q      <= sect;
      c_offs_zero_q <= (offs == 6'd0);
    end
    if (c_valid_q && d_rdy) begin
      d_mode_q      <= c_mode_q;
      d_d1_q        <= q1[8] ? END_MAX : q1[7:0];
      d_d2_q        <= q2[8] ? END_MAX : q2[7:0];
      d_sect_q      <= c_sect_q;
      d_offs_zero_q <= c_offs_zero_q;
    end
  end

  // state update: new angle or one tick
  logic [8:0] end_sum;
  logic [7:0] end_two;
  logic [2:0] vec_one, vec_two;
  logic [7:0] tick_inc;

  assign end_sum  = 9'(d_d1_q) + 9'(d_d2_q);
  assign end_two  = end_sum[8] ? END_MAX : end_sum[7:0];
  assign vec_one  = sector_vec(d_sect_q);
  assign vec_two  = d_offs_zero_q ? vec_one : sector_vec(3'(d_sect_q + 3'd1));
  assign tick_inc = tick_q + 8'd1;

  always_comb begin
    tick_d       = tick_q;
    cmp_a_d      = cmp_a_q;
    cmp_b_d      = cmp_b_q;
    nxt_first_d  = nxt_first_q;
    nxt_second_d = nxt_second_q;
    first_vec_d  = first_vec_q;
    second_vec_d = second_vec_q;
    zero_vec_d   = zero_vec_q;
    drive_d      = drive_q;
    if (mode_e'(d_mode_q) == MODE_SET_ANGLE) begin
      first_vec_d  = vec_one;
      second_vec_d = vec_two;
      zero_vec_d   = zero_for(vec_two);
      nxt_first_d  = d_d1_q;
      nxt_second_d = end_two;
      tick_d       = 8'd0;
      cmp_a_d      = d_d1_q;
      cmp_b_d      = end_two;
      drive_d      = vec_one;
    end else begin
      tick_d = tick_inc;
      if (tick_inc == cmp_a_q && cmp_a_q != cmp_b_q && cmp_a_q != 8'd0) begin
        drive_d = second_vec_q;
      end
      if (tick_inc == cmp_b_q) begin
        drive_d = zero_vec_q;
        cmp_a_d = nxt_first_q;
        cmp_b_d = nxt_second_q;
      end
      if (tick_inc == 8'd0) begin
        drive_d = first_vec_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= 8'd0;
      cmp_a_q      <= START_END;
      cmp_b_q      <= START_END;
      nxt_first_q  <= START_END;
      nxt_second_q <= START_END;
      first_vec_q  <= VEC_RESET;
      second_vec_q <= VEC_RESET;
      zero_vec_q   <= VEC_ZERO_LOW;
      drive_q      <= VEC_RESET;
    end else if (upd) begin
      tick_q       <= tick_d;
      cmp_a_q      <= cmp_a_d;
      cmp_b_q      <= cmp_b_d;
      nxt_first_q  <= nxt_first_d;
      nxt_second_q <= nxt_second_d;
      first_vec_q  <= first_vec_d;
      second_vec_q <= second_vec_d;
      zero_vec_q   <= zero_vec_d;
      drive_q      <= drive_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign phase_bits_o = drive_q;
  assign first_end_o  = cmp_a_q;
  assign second_end_o = cmp_b_q;

  // compare B never ends before compare A
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_a_q <= cmp_b_q)
    else $error("compare B below compare A");

  // a new angle restarts the counter on the first vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && mode_e'(d_mode_q) == MODE_SET_ANGLE |=> tick_q == 8'd0 && drive_q == first_vec_q)
    else $error("set angle did not restart the counter");

  // a tick advances the counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && mode_e'(d_mode_q) == MODE_TICK |=> tick_q == 8'($past(tick_q) + 8'd1))
    else $error("tick did not advance the counter");

  // the pwm state moves only when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(drive_q) && $stable(tick_q) && $stable(cmp_b_q))
    else $error("state changed without a result");

  // zero vector is all low or all high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_vec_q == VEC_ZERO_LOW || zero_vec_q == VEC_ZERO_HIGH)
    else $error("bad zero vector");

endmodule
